### rtl/core/jse_pkg.sv
package jse_pkg;

   // command codes of a request word
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // character constants
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] ASCII_TOP   = 8'h7f;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // position within one escape sequence (up to six characters)
   localparam int IDX_WIDTH = 3;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // how a word is to be written out
   typedef enum logic [1:0] {
      KIND_QUOTE,
      KIND_PLAIN,
      KIND_PAIR,
      KIND_HEX
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } desc_type;

   // number of output characters for a kind
   function automatic logic [IDX_WIDTH-1:0] desc_len(input kind_type kind);
      logic [IDX_WIDTH-1:0] len;
      case (kind)
         KIND_QUOTE: len = IDX_WIDTH'(1);
         KIND_PLAIN: len = IDX_WIDTH'(1);
         KIND_PAIR:  len = IDX_WIDTH'(2);
         KIND_HEX:   len = IDX_WIDTH'(6);
         default:    len = IDX_WIDTH'(1);
      endcase
      return len;
   endfunction

   // lowercase hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, nib};
      end else begin
         ch = CHAR_A + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

   // character at position idx of a descriptor's output
   function automatic logic [7:0] desc_char(input desc_type d,
                                            input logic [IDX_WIDTH-1:0] idx);
      logic [7:0] ch;
      case (d.kind)
         KIND_QUOTE: ch = CHAR_QUOTE;
         KIND_PLAIN: ch = d.value;
         KIND_PAIR:  ch = (idx == IDX_WIDTH'(0)) ? CHAR_BSLASH : d.value;
         KIND_HEX: begin
            case (idx)
               IDX_WIDTH'(0): ch = CHAR_BSLASH;
               IDX_WIDTH'(1): ch = CHAR_U;
               IDX_WIDTH'(2): ch = CHAR_ZERO;
               IDX_WIDTH'(3): ch = CHAR_ZERO;
               IDX_WIDTH'(4): ch = hex_char(d.value[7:4]);
               default:       ch = hex_char(d.value[3:0]);
            endcase
         end
         default:    ch = CHAR_QUOTE;
      endcase
      return ch;
   endfunction

endpackage

### rtl/core/json_string_escape_encoder.sv
// JSON string escape encoder
// Request channel: a word (command, data_byte) is taken at a rising edge
// where start is high and busy is low. Command start or end gives a quote
// character, a data command gives the byte itself, a backslash pair for
// quote and backslash, or a six-character \u00xx escape for bytes below
// 0x20 or above 0x7f. Command 3 is dropped and gives nothing.
// Response channel: each output character appears on rsp_word for one
// cycle with rsp_strobe high; last marks the final character of a word.
// A taken word is written into the queue, then loaded into the sequencer's
// current descriptor register, and each character is registered on rsp_word.
// Throughput: one output character per cycle, set by the back end
// sequencer; plain bytes and quotes therefore sustain one word per cycle,
// pairs give two characters and hex escapes six. A four-entry descriptor
// queue between the classifier and the sequencer absorbs escape bursts;
// busy is high while that queue is full.
// Reset empties the queue and the sequencer; no output follows reset until
// new words arrive. The receiver cannot stall, so no output is ever held.
module json_string_escape_encoder
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   logic     push;
   desc_type push_desc;
   logic     pop;
   desc_type head_desc;
   logic     queue_empty;
   logic     queue_full;

   assign busy = queue_full;

   // classifier
   jse_front u_front (
      .start      (start),
      .queue_full (queue_full),
      .req_word   (req_word),
      .push       (push),
      .push_desc  (push_desc)
   );

   // descriptor queue
   jse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // character sequencer
   jse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_desc   (head_desc),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

endmodule

### rtl/core/jse_front.sv
module jse_front
   import jse_pkg::*;
(
   input  logic     start,
   input  logic     queue_full,
   input  req_type  req_word,
   output logic     push,
   output desc_type push_desc
);

   logic accept;

   // word taken when start is high and the queue has room
   assign accept = start && !queue_full;

   // classify the word into a descriptor; unused command is dropped
   always_comb begin
      push           = 1'b0;
      push_desc.kind = KIND_QUOTE;
      push_desc.value = req_word.data_byte;
      case (req_word.command)
         CMD_START, CMD_END: begin
            push           = accept;
            push_desc.kind = KIND_QUOTE;
         end
         CMD_DATA: begin
            push = accept;
            if (req_word.data_byte == CHAR_QUOTE || req_word.data_byte == CHAR_BSLASH) begin
               push_desc.kind = KIND_PAIR;
            end else if (req_word.data_byte < CTRL_LIMIT ||
                         req_word.data_byte > ASCII_TOP) begin
               push_desc.kind = KIND_HEX;
            end else begin
               push_desc.kind = KIND_PLAIN;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/jse_queue.sv
module jse_queue
   import jse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head_desc,
   output logic     empty,
   output logic     full
);

   desc_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign empty     = (count_ff == CNT_WIDTH'(0));
   assign full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign head_desc = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### rtl/core/jse_back.sv
module jse_back
   import jse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     queue_empty,
   input  desc_type head_desc,
   output logic     pop,
   output logic     rsp_strobe,
   output rsp_type  rsp_word
);

   desc_type             cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              word_ff, word_in;
   logic                 done;

   // current sequence finishes on its last character
   assign done = cur_valid_ff && (idx_ff == desc_len(cur_ff.kind) - IDX_WIDTH'(1));
   assign pop  = !queue_empty && (!cur_valid_ff || done);

   // sequencer: one character per cycle, next descriptor loaded on the last
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = head_desc;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (cur_valid_ff) begin
         idx_in = idx_ff + IDX_WIDTH'(1);
      end
      strobe_in        = cur_valid_ff;
      word_in.out_byte = desc_char(cur_ff, idx_ff);
      word_in.last     = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         strobe_ff    <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule

### verif/jse_escape_checker.sv
module jse_escape_checker
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_strobe,
   input  rsp_type rsp_word,
   output int      mismatch_count,
   output int      open_count
);

   // hex digits, most significant character first
   localparam logic [8*16-1:0] HEX_TEXT = "0123456789abcdef";

   rsp_type expected_chars[$];
   rsp_type head;
   int      errors = 0;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return HEX_TEXT[8*(15 - int'(nib)) +: 8];
   endfunction

   // escaped text of one accepted word, last flag on its final character
   task automatic encode_word(input req_type w);
      logic [7:0] chars [6];
      int         n;
      logic [7:0] b;
      n = 0;
      b = w.data_byte;
      case (w.command)
         CMD_START, CMD_END: begin
            chars[0] = CHAR_QUOTE;
            n = 1;
         end
         CMD_DATA: begin
            if (b == CHAR_QUOTE || b == CHAR_BSLASH) begin
               chars[0] = CHAR_BSLASH;
               chars[1] = b;
               n = 2;
            end else if (b < CTRL_LIMIT || b > ASCII_TOP) begin
               chars[0] = CHAR_BSLASH;
               chars[1] = CHAR_U;
               chars[2] = CHAR_ZERO;
               chars[3] = CHAR_ZERO;
               chars[4] = hex_digit(b[7:4]);
               chars[5] = hex_digit(b[3:0]);
               n = 6;
            end else begin
               chars[0] = b;
               n = 1;
            end
         end
         default: n = 0;
      endcase
      for (int i = 0; i < n; i++) begin
         expected_chars.insert(expected_chars.size(),
                               '{out_byte: chars[i], last: (i == n - 1)});
      end
   endtask

   // compare each output character with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
      end else begin
         if (rsp_strobe !== 1'b0) begin
            if (expected_chars.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("checker: unexpected output char=%h last=%b",
                           rsp_word.out_byte, rsp_word.last);
               end
            end else begin
               head = expected_chars.pop_front();
               if (rsp_strobe !== 1'b1 || rsp_word.out_byte !== head.out_byte ||
                   rsp_word.last !== head.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("checker: mismatch char exp=%h got=%h last exp=%b got=%b",
                              head.out_byte, rsp_word.out_byte, head.last, rsp_word.last);
                  end
               end
            end
         end
         if (start && !busy) begin
            encode_word(req_word);
         end
      end
      mismatch_count <= errors;
      open_count     <= expected_chars.size();
   end

endmodule

### verif/tb_json_string_escape_encoder.sv
module tb_json_string_escape_encoder;
   import jse_pkg::*;

   // command code that the block drops
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;
   int      mismatch_count;
   int      open_count;
   int      words_sent;

   always #5 clock = ~clock;

   json_string_escape_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   jse_escape_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   function automatic req_type make_word(input logic [1:0] cmd, input logic [7:0] b);
      req_type w;
      w.command   = cmd;
      w.data_byte = b;
      return w;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // string byte: mostly printable, with quotes, backslashes and hex escapes
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3, 4, 5: return 8'($urandom_range(8'h20, 8'h7f));
         6: return ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : CHAR_BSLASH;
         7: return 8'($urandom_range(8'h00, 8'h1f));
         8: return 8'($urandom_range(8'h80, 8'hff));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // present one word from the falling edge, hold until taken
   task automatic send_word(input req_type w, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (w.command != CMD_UNUSED) begin
         words_sent++;
      end
   endtask

   // one string: start, random bytes, end; sometimes broken or noisy
   task automatic send_string();
      int len;
      int burst;
      len   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
         send_word(make_word(CMD_START, 8'($urandom)), burst ? 0 : pick_gap());
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 12) == 0) begin
            send_word(make_word(CMD_UNUSED, 8'($urandom)), burst ? 0 : pick_gap());
         end
         if ($urandom_range(0, 25) == 0) begin
            send_word(make_word(2'($urandom_range(0, 2)), 8'($urandom)),
                      burst ? 0 : pick_gap());
         end
         send_word(make_word(CMD_DATA, pick_byte()), burst ? 0 : pick_gap());
      end
      if ($urandom_range(0, 9) != 0) begin
         send_word(make_word(CMD_END, 8'($urandom)), burst ? 0 : pick_gap());
      end
   endtask

   initial begin
      words_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: quotes, plain bytes, pairs, hex escapes, edges of ranges
      send_word(make_word(CMD_START, 8'hff), 0);
      send_word(make_word(CMD_DATA, 8'h61), 0);
      send_word(make_word(CMD_DATA, CHAR_QUOTE), 0);
      send_word(make_word(CMD_DATA, CHAR_BSLASH), 0);
      send_word(make_word(CMD_DATA, 8'h00), 0);
      send_word(make_word(CMD_DATA, 8'h0a), 0);
      send_word(make_word(CMD_DATA, 8'h09), 0);
      send_word(make_word(CMD_DATA, 8'h1f), 0);
      send_word(make_word(CMD_DATA, 8'h20), 0);
      send_word(make_word(CMD_DATA, 8'h7e), 0);
      // delete passes through unchanged
      send_word(make_word(CMD_DATA, 8'h7f), 0);
      send_word(make_word(CMD_DATA, 8'h80), 0);
      send_word(make_word(CMD_DATA, 8'hff), 0);
      send_word(make_word(CMD_DATA, 8'ha5), 2);
      send_word(make_word(CMD_DATA, 8'h5a), 0);
      send_word(make_word(CMD_END, 8'h5a), 0);
      // dropped command, any data
      send_word(make_word(CMD_UNUSED, 8'hff), 0);
      send_word(make_word(CMD_UNUSED, 8'h00), 1);
      // unmatched end and doubled start
      send_word(make_word(CMD_END, 8'h00), 0);
      send_word(make_word(CMD_START, 8'h00), 0);
      send_word(make_word(CMD_START, CHAR_QUOTE), 0);
      send_word(make_word(CMD_DATA, 8'hc3), 0);
      send_word(make_word(CMD_DATA, 8'h01), 0);
      send_word(make_word(CMD_END, 8'h80), 5);

      // random strings
      while (words_sent < 245) begin
         send_string();
      end
      start <= 1'b0;

      // drain, then wait for anything stray
      while (open_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
